@@ rtl/core/block_index_record_parser_macros.svh @@
// Assertion macros for the block index record parser.
// Used by block_index_record_parser.sv; expects clk and rst_n in scope.
`ifndef BLOCK_INDEX_RECORD_PARSER_MACROS_SVH
`define BLOCK_INDEX_RECORD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define BIPR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BIPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BIPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BIPR_ASSERT(lbl, expr)
`define BIPR_ASSERT_IMP(lbl, ante, cons)
`define BIPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/bipr_pkg.sv @@
// Package for the block index record parser: field codes and result type.
// No dependencies.
package bipr_pkg;

    localparam int unsigned PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_CLIENTVER = 5'd0;
    localparam logic [PHASE_W-1:0] PH_HEIGHT    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_STATUS    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_NTX       = 5'd3;
    localparam logic [PHASE_W-1:0] PH_FILE      = 5'd4;
    localparam logic [PHASE_W-1:0] PH_DATAPOS   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_UNDOPOS   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_HDRVER    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_PREV0     = 5'd8;
    localparam logic [PHASE_W-1:0] PH_MERKLE3   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_NONCE     = 5'd18;

    localparam logic [2:0] TOP_WORD  = 3'd3;
    localparam logic [2:0] TOP_CHUNK = 3'd7;

    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        phase_t      field_id;
        logic [63:0] field_value;
        logic        record_done;
        logic        short_record;
    } result_t;

endpackage

@@ rtl/core/bipr_decode.sv @@
// Record decoder: field phase state, varint and fixed-width accumulators.
// Depends on bipr_pkg.
module bipr_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rec_byte,
    input  logic               rec_last,
    output logic               res_valid,
    output bipr_pkg::result_t  res
);

    bipr_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      varint_reg, varint_next;
    logic [2:0]       count_reg, count_next;
    logic [63:0]      fixed_reg, fixed_next;
    logic [1:0]       hdu_reg, hdu_next;
    logic             fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bipr_pkg::PH_CLIENTVER;
            varint_reg <= '0;
            count_reg  <= '0;
            fixed_reg  <= '0;
            hdu_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            varint_reg <= varint_next;
            count_reg  <= count_next;
            fixed_reg  <= fixed_next;
            hdu_reg    <= hdu_next;
            fin_reg    <= fin_next;
        end
    end

    always_comb
    begin
        logic [31:0]      acc;
        logic [63:0]      ins;
        logic [63:0]      fixed_new;
        logic [2:0]       top;
        logic             done_f;
        logic [63:0]      val;
        bipr_pkg::phase_t after_var;

        phase_next  = phase_reg;
        varint_next = varint_reg;
        count_next  = count_reg;
        fixed_next  = fixed_reg;
        hdu_next    = hdu_reg;
        fin_next    = fin_reg;
        done_f      = 1'b0;
        val         = '0;

        acc = {varint_reg[24:0], rec_byte[6:0]};
        for (int i = 0; i < 8; i++)
        begin
            ins[i*8 +: 8] = (count_reg == 3'(i)) ? rec_byte : 8'h00;
        end
        fixed_new = fixed_reg | ins;
        top = (phase_reg >= bipr_pkg::PH_PREV0 && phase_reg <= bipr_pkg::PH_MERKLE3)
              ? bipr_pkg::TOP_CHUNK : bipr_pkg::TOP_WORD;

        unique case (phase_reg)
            bipr_pkg::PH_CLIENTVER: after_var = bipr_pkg::PH_HEIGHT;
            bipr_pkg::PH_HEIGHT:    after_var = bipr_pkg::PH_STATUS;
            bipr_pkg::PH_STATUS:    after_var = bipr_pkg::PH_NTX;
            bipr_pkg::PH_NTX:
                after_var = (hdu_reg != 2'b00) ? bipr_pkg::PH_FILE : bipr_pkg::PH_HDRVER;
            bipr_pkg::PH_FILE:
                after_var = hdu_reg[0] ? bipr_pkg::PH_DATAPOS :
                            (hdu_reg[1] ? bipr_pkg::PH_UNDOPOS : bipr_pkg::PH_HDRVER);
            bipr_pkg::PH_DATAPOS:
                after_var = hdu_reg[1] ? bipr_pkg::PH_UNDOPOS : bipr_pkg::PH_HDRVER;
            default:                after_var = bipr_pkg::PH_HDRVER;
        endcase

        if (!fin_reg)
        begin
            if (phase_reg < bipr_pkg::PH_HDRVER)
            begin
                if (rec_byte[7])
                begin
                    varint_next = acc + 32'd1;
                end
                else
                begin
                    done_f      = 1'b1;
                    val         = {32'h0, acc};
                    varint_next = '0;
                    phase_next  = after_var;
                    if (phase_reg == bipr_pkg::PH_STATUS)
                    begin
                        hdu_next = acc[4:3];
                    end
                end
            end
            else
            begin
                if (count_reg >= top)
                begin
                    done_f     = 1'b1;
                    val        = fixed_new;
                    fixed_next = '0;
                    count_next = '0;
                    if (phase_reg >= bipr_pkg::PH_NONCE)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 5'd1;
                    end
                end
                else
                begin
                    fixed_next = fixed_new;
                    count_next = count_reg + 3'd1;
                end
            end
        end

        res_valid        = done_f || (rec_last && !fin_reg);
        res.field_id     = phase_reg;
        res.field_value  = done_f ? val : 64'h0;
        res.record_done  = fin_next || rec_last;
        res.short_record = rec_last && !fin_next;

        if (rec_last)
        begin
            phase_next  = bipr_pkg::PH_CLIENTVER;
            varint_next = '0;
            count_next  = '0;
            fixed_next  = '0;
            hdu_next    = '0;
            fin_next    = 1'b0;
        end
    end

endmodule

@@ rtl/core/block_index_record_parser.sv @@
// Block index record parser top level: input register, decoder, result register.
// An item passes from the input register through the decoder into the result register, which drives m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the result register; the decoder state update is the only loop.
// Reset: rst_n clears both stage valids and the decoder state to the first field.
// Depends on bipr_pkg, bipr_decode and block_index_record_parser_macros.svh.
`include "block_index_record_parser_macros.svh"
module block_index_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rec_byte
    input  logic        s_tlast,    // rec_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [4:0] field_id, [68:5] field_value, zero pad
    output logic        m_tlast,    // record_done
    output logic [0:0]  m_tuser     // [0] short_record
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               adv;
    logic               res_valid;
    bipr_pkg::result_t  res;
    logic               out_vld_reg;
    bipr_pkg::result_t  out_reg;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (adv && res_valid)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (adv && res_valid)
        begin
            out_reg <= res;
        end
    end

    bipr_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .rec_byte  (in_byte_reg),
        .rec_last  (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg.field_value, out_reg.field_id};
    assign m_tlast  = out_reg.record_done;
    assign m_tuser  = out_reg.short_record;

    `BIPR_ASSERT_IMP(a_short_ends_record, m_tvalid && m_tuser[0], m_tlast)
    `BIPR_ASSERT_IMP(a_no_overwrite, out_vld_reg && !m_tready, !adv)
    `BIPR_ASSERT_IMP(a_field_id_range, m_tvalid, m_tdata[4:0] <= bipr_pkg::PH_NONCE)
    `BIPR_ASSERT_NXT(a_result_loaded, adv && res_valid, out_vld_reg)

endmodule

@@ verif/block_index_record_parser_field_check.sv @@
`timescale 1ns / 1ps
// Field checker for block_index_record_parser: decodes each accepted record byte,
// queues the field it completes and compares it against the result stream.
// Depends on bipr_pkg.
module block_index_record_parser_field_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output int unsigned fields_checked,
    output int unsigned early_ends,
    output int unsigned full_records
);

    bipr_pkg::phase_t  cur_phase;
    logic [31:0]       varint_acc;
    logic [2:0]        word_cnt;
    logic [63:0]       word_acc;
    logic [1:0]        pos_flags;     // [0] data position present, [1] undo position present
    logic              nonce_seen;
    bipr_pkg::result_t pending_fields[$];
    int unsigned       err_n, field_n, early_n, full_n;

    function automatic bipr_pkg::phase_t after_varint(bipr_pkg::phase_t ph,
                                                      logic [1:0] flags);
        case (ph)
            bipr_pkg::PH_CLIENTVER: return bipr_pkg::PH_HEIGHT;
            bipr_pkg::PH_HEIGHT:    return bipr_pkg::PH_STATUS;
            bipr_pkg::PH_STATUS:    return bipr_pkg::PH_NTX;
            bipr_pkg::PH_NTX:
                return (flags != 2'b00) ? bipr_pkg::PH_FILE : bipr_pkg::PH_HDRVER;
            bipr_pkg::PH_FILE:
                return flags[0] ? bipr_pkg::PH_DATAPOS
                                : (flags[1] ? bipr_pkg::PH_UNDOPOS : bipr_pkg::PH_HDRVER);
            bipr_pkg::PH_DATAPOS:
                return flags[1] ? bipr_pkg::PH_UNDOPOS : bipr_pkg::PH_HDRVER;
            default:                return bipr_pkg::PH_HDRVER;
        endcase
    endfunction

    task automatic clear_parser();
        cur_phase  = bipr_pkg::PH_CLIENTVER;
        varint_acc = '0;
        word_cnt   = '0;
        word_acc   = '0;
        pos_flags  = '0;
        nonce_seen = 1'b0;
    endtask

    task automatic decode_record_byte(input logic [7:0] b, input logic last);
        bipr_pkg::result_t fld;
        logic              hit;
        logic              was_done;
        logic [2:0]        top;
        hit             = 1'b0;
        was_done        = nonce_seen;
        fld.field_id    = cur_phase;
        fld.field_value = '0;
        if (!was_done)
        begin
            if (cur_phase < bipr_pkg::PH_HDRVER)
            begin
                varint_acc = {varint_acc[24:0], b[6:0]};
                if (b[7])
                begin
                    varint_acc = varint_acc + 32'd1;
                end
                else
                begin
                    hit             = 1'b1;
                    fld.field_value = {32'd0, varint_acc};
                    if (cur_phase == bipr_pkg::PH_STATUS)
                        pos_flags = varint_acc[4:3];
                    varint_acc = '0;
                    cur_phase  = after_varint(cur_phase, pos_flags);
                end
            end
            else
            begin
                top = (cur_phase >= bipr_pkg::PH_PREV0 && cur_phase <= bipr_pkg::PH_MERKLE3)
                      ? bipr_pkg::TOP_CHUNK : bipr_pkg::TOP_WORD;
                word_acc = word_acc | ({56'd0, b} << (8 * word_cnt));
                if (word_cnt >= top)
                begin
                    hit             = 1'b1;
                    fld.field_value = word_acc;
                    word_acc        = '0;
                    word_cnt        = '0;
                    if (cur_phase >= bipr_pkg::PH_NONCE)
                        nonce_seen = 1'b1;
                    else
                        cur_phase = cur_phase + 1'b1;
                end
                else
                begin
                    word_cnt = word_cnt + 3'd1;
                end
            end
        end
        // an unfinished field at the record end still reports, with value zero
        fld.record_done  = nonce_seen | last;
        fld.short_record = last & ~nonce_seen;
        if (hit || (last && !was_done))
            pending_fields.push_back(fld);
        if (last)
            clear_parser();
    endtask

    task automatic check_field(input bipr_pkg::result_t got);
        bipr_pkg::result_t want;
        if (pending_fields.size() == 0)
        begin
            if (err_n < 10)
                $display("%0t: unexpected item id=%0d value=%h done=%b short=%b", $realtime,
                         got.field_id, got.field_value, got.record_done, got.short_record);
            err_n++;
        end
        else
        begin
            want = pending_fields.pop_front();
            field_n++;
            if (want.record_done && want.short_record)
                early_n++;
            else if (want.record_done)
                full_n++;
            if (got.field_id !== want.field_id || got.field_value !== want.field_value ||
                got.record_done !== want.record_done ||
                got.short_record !== want.short_record)
            begin
                if (err_n < 10)
                    $display("%0t: mismatch exp %0d/%h/%b/%b got %0d/%h/%b/%b",
                             $realtime, want.field_id, want.field_value, want.record_done,
                             want.short_record, got.field_id, got.field_value,
                             got.record_done, got.short_record);
                err_n++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bipr_pkg::result_t got;
        if (!rst_n)
        begin
            clear_parser();
            pending_fields.delete();
            err_n   = 0;
            field_n = 0;
            early_n = 0;
            full_n  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_record_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.field_id     = m_tdata[4:0];
                got.field_value  = m_tdata[68:5];
                got.record_done  = m_tlast;
                got.short_record = m_tuser[0];
                check_field(got);
            end
        end
        mismatches     <= err_n;
        outstanding    <= pending_fields.size();
        fields_checked <= field_n;
        early_ends     <= early_n;
        full_records   <= full_n;
    end

endmodule

@@ verif/tb_block_index_record_parser.sv @@
`timescale 1ns / 1ps
// Testbench top for block_index_record_parser: drives directed and random records
// under random stalls and reports the verdict from the field checker.
// Depends on block_index_record_parser and block_index_record_parser_field_check.
module tb_block_index_record_parser;

    localparam int unsigned RANDOM_BYTES = 1050;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned fields_checked;
    int unsigned early_ends;
    int unsigned full_records;

    int unsigned sender_idle_pct   = 23;
    int unsigned receiver_idle_pct = 86;
    int unsigned bytes_sent        = 0;
    int unsigned records_sent      = 0;
    int unsigned cycles            = 0;
    logic [7:0]  rec_q[$];

    block_index_record_parser uut (.*);

    block_index_record_parser_field_check checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d fields outstanding", cycles, outstanding);
            $display("block_index_record_parser regression: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++)
            send_byte(rec_q[i], i == rec_q.size() - 1);
        records_sent++;
    endtask

    task automatic add_varint();
        int unsigned r;
        int unsigned n;
        logic [7:0]  b;
        r = $urandom_range(9);
        n = (r < 5) ? 1 : ((r < 8) ? $urandom_range(3, 2) : $urandom_range(8, 4));
        for (int k = 0; k < n; k++)
        begin
            b    = 8'($urandom_range(255));
            b[7] = (k != n - 1);
            rec_q.push_back(b);
        end
    endtask

    task automatic build_record();
        logic [1:0]  flags;
        int unsigned mode;
        int unsigned cut;
        rec_q.delete();
        if ($urandom_range(7) == 0)
        begin
            // noise: random bytes of arbitrary shape
            repeat ($urandom_range(24, 1)) rec_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            add_varint();
            add_varint();
            add_varint();
            flags = rec_q[rec_q.size() - 1][4:3];
            add_varint();
            if (flags != 2'b00)
                add_varint();
            if (flags[0])
                add_varint();
            if (flags[1])
                add_varint();
            repeat (80) rec_q.push_back(8'($urandom_range(255)));
            mode = $urandom_range(9);
            if (mode >= 8)
            begin
                cut = $urandom_range(rec_q.size() - 1, 1);
                while (rec_q.size() > cut)
                    void'(rec_q.pop_back());
            end
            else if (mode >= 6)
            begin
                repeat ($urandom_range(5, 1)) rec_q.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        int unsigned random_start;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // field completes on the last byte, and a varint cut off mid-field
        rec_q = {8'h00};
        send_record();
        rec_q = {8'hFF};
        send_record();
        rec_q = {8'h7F, 8'h81};
        send_record();
        // long varint that wraps, then height ending the record
        rec_q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F};
        send_record();
        // both position flags, record cut inside the data position
        rec_q = {8'h01, 8'h02, 8'h18, 8'h03, 8'h04, 8'h85};
        send_record();
        // undo position only
        rec_q = {8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00};
        send_record();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (bytes_sent - random_start >= 2 * RANDOM_BYTES / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            else if (bytes_sent - random_start >= RANDOM_BYTES / 3)
            begin
                sender_idle_pct   = 86;
                receiver_idle_pct = 23;
            end
            build_record();
            send_record();
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d records, directed and random, stalls on both sides",
                 bytes_sent, records_sent);
        $display("compared %0d fields: %0d records ran through the nonce, %0d ended early",
                 fields_checked, full_records, early_ends);
        if (mismatches == 0)
            $display("block_index_record_parser regression: pass");
        else
            $display("block_index_record_parser regression: fail");
        $finish;
    end

endmodule
